// ===== hw/rtl/gpx_pkg.sv =====
// Shared types, codes and bit-count helpers of the GPIO expander pin-change packer.
package gpx_pkg;

    localparam int NUM_PORTS  = 3;
    localparam int PORT_W     = 8;
    localparam int WORD_W     = 16;
    localparam int OFFSET_W   = 5;

    // Input command codes.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Port select codes, also the configuration register indexes of the masks.
    localparam logic [1:0] PORT_D = 2'd0;
    localparam logic [1:0] PORT_B = 2'd1;
    localparam logic [1:0] PORT_C = 2'd2;

    // Host command codes.
    localparam logic [1:0] CODE_NOP        = 2'd0;
    localparam logic [1:0] CODE_GET_STATUS = 2'd1;
    localparam logic [1:0] CODE_POWER_DOWN = 2'd2;

    // Mask reset values.
    localparam logic [PORT_W-1:0] MASK_D_RESET = 8'd255;
    localparam logic [PORT_W-1:0] MASK_B_RESET = 8'd63;
    localparam logic [PORT_W-1:0] MASK_C_RESET = 8'd63;

    typedef logic [PORT_W-1:0] port_vec_t [NUM_PORTS];

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        port_select;
        logic [PORT_W-1:0] pin_levels;
        logic [1:0]        host_code;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              read_valid;
        logic              int_request;
        logic              sleeping;
    } out_item_t;

    // Line levels and read outcome after one request.
    typedef struct packed {
        logic status_read;
        logic irq;
        logic asleep;
    } flags_t;

    // Number of set bits of a mask.
    function automatic logic [3:0] popcount8(input logic [PORT_W-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < PORT_W; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    // Position of the lowest set bit; zero for an empty mask.
    function automatic logic [2:0] lowest_bit8(input logic [PORT_W-1:0] v);
        logic [2:0] pos;
        pos = '0;
        for (int i = PORT_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/gpio_expander_pin_change_packer_core.sv =====
// Top level of the GPIO expander pin-change packer: input stage, state, packing, result stage.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_stall  in_data  (gpx_pkg::in_item_t)
//   out       result     out_valid / out_stall out_data (gpx_pkg::out_item_t)
//   cfg       write      cfg_we               cfg_index, cfg_data
//
// One request per cycle while out_stall holds nothing back; each request is loaded into the input register when
// accepted, and its result is loaded into the result register once that register is free.
// The state update and the status packing sit in the single stage between the two
// registers. Reset loads the masks with their defaults and clears the valid bits and the gpx_state registers to zero.
// A stalled result holds in the result register; the input register keeps taking a
// new request as long as the result register is free or being drained.
module gpio_expander_pin_change_packer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gpx_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gpx_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [gpx_pkg::PORT_W-1:0]    cfg_data
);

    gpx_pkg::port_vec_t         mask_reg;
    gpx_pkg::in_item_t          s1_item_reg;
    logic                       s1_valid_reg;
    logic                       out_valid_reg;
    gpx_pkg::out_item_t         out_item_reg;
    gpx_pkg::out_item_t         out_item_next;
    gpx_pkg::port_vec_t         latched;
    gpx_pkg::flags_t            flags;
    logic [gpx_pkg::WORD_W-1:0] word;
    logic                       out_free;
    logic                       s1_fire;
    logic                       in_take;

    // Handshake: the stage moves when the result register is empty or drains.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Mask registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[0] <= gpx_pkg::MASK_D_RESET;
            mask_reg[1] <= gpx_pkg::MASK_B_RESET;
            mask_reg[2] <= gpx_pkg::MASK_C_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gpx_pkg::PORT_D: mask_reg[0] <= cfg_data;
                gpx_pkg::PORT_B: mask_reg[1] <= cfg_data;
                gpx_pkg::PORT_C: mask_reg[2] <= cfg_data;
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_fire)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
    end

    gpx_state u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .item    (s1_item_reg),
        .masks   (mask_reg),
        .latched (latched),
        .flags   (flags)
    );

    gpx_packer u_packer
    (
        .masks   (mask_reg),
        .latched (latched),
        .word    (word)
    );

    // Result assembly.
    always_comb
    begin
        out_item_next.read_data   = flags.status_read ? word : '0;
        out_item_next.read_valid  = flags.status_read;
        out_item_next.int_request = flags.irq;
        out_item_next.sleeping    = flags.asleep;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // A status read always drops the interrupt line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.read_valid |-> !out_data.int_request)
        else $error("status read left the interrupt line high");

    // Read data is zero unless the read returned status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.read_valid |-> out_data.read_data == '0)
        else $error("read data without a status read");

    // The input side stalls only behind a full, blocked pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // A request waiting in the input register moves on once the result drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_stall |=> out_valid)
        else $error("result register lost a request");

endmodule

// ===== hw/rtl/gpx_packer.sv =====
// Packs the masked port levels into the 16-bit pin status word.
module gpx_packer
(
    input  gpx_pkg::port_vec_t          masks,
    input  gpx_pkg::port_vec_t          latched,
    output logic [gpx_pkg::WORD_W-1:0]  word
);

    logic [gpx_pkg::PORT_W-1:0]   field   [gpx_pkg::NUM_PORTS];
    logic [gpx_pkg::OFFSET_W-1:0] offset  [gpx_pkg::NUM_PORTS];
    logic [gpx_pkg::WORD_W-1:0]   placed  [gpx_pkg::NUM_PORTS];

    // Each field is right-aligned to its lowest mask bit.
    always_comb
    begin
        for (int p = 0; p < gpx_pkg::NUM_PORTS; p++)
        begin
            field[p] = (latched[p] & masks[p]) >> gpx_pkg::lowest_bit8(masks[p]);
        end
    end

    // Running offsets: port D at zero, then by the popcounts of the earlier masks.
    always_comb
    begin
        offset[0] = '0;
        for (int p = 1; p < gpx_pkg::NUM_PORTS; p++)
        begin
            offset[p] = offset[p-1]
                      + gpx_pkg::OFFSET_W'(gpx_pkg::popcount8(masks[p-1]));
        end
    end

    // Place and merge; bits shifted past the word are dropped.
    always_comb
    begin
        word = '0;
        for (int p = 0; p < gpx_pkg::NUM_PORTS; p++)
        begin
            placed[p] = gpx_pkg::WORD_W'(field[p]) << offset[p];
            word      = word | placed[p];
        end
    end

endmodule

// ===== hw/rtl/gpx_state.sv =====
// Latched levels, pending command code, interrupt line and power-down flag.
module gpx_state
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  gpx_pkg::in_item_t   item,
    input  gpx_pkg::port_vec_t  masks,
    output gpx_pkg::port_vec_t  latched,
    output gpx_pkg::flags_t     flags
);

    logic [gpx_pkg::PORT_W-1:0] latched_reg [gpx_pkg::NUM_PORTS];
    logic [gpx_pkg::PORT_W-1:0] latched_next [gpx_pkg::NUM_PORTS];
    logic [1:0]                 pending_reg, pending_next;
    logic                       irq_reg, irq_next;
    logic                       asleep_reg, asleep_next;
    logic                       status_read;
    logic [gpx_pkg::PORT_W-1:0] sample;

    // Next-state logic for one request.
    always_comb
    begin
        latched_next = latched_reg;
        pending_next = pending_reg;
        irq_next     = irq_reg;
        asleep_next  = asleep_reg;
        status_read  = 1'b0;
        sample       = '0;
        case (item.cmd)
            gpx_pkg::CMD_SAMPLE:
            begin
                if (item.port_select inside {gpx_pkg::PORT_D, gpx_pkg::PORT_B,
                                             gpx_pkg::PORT_C})
                begin
                    sample = item.pin_levels & masks[item.port_select];
                    if (sample != latched_reg[item.port_select])
                    begin
                        latched_next[item.port_select] = sample;
                        irq_next    = 1'b1;
                        asleep_next = 1'b0;
                    end
                end
            end
            gpx_pkg::CMD_WRITE:
            begin
                if (item.host_code == gpx_pkg::CODE_POWER_DOWN)
                begin
                    asleep_next = 1'b1;
                end
                else
                begin
                    pending_next = item.host_code;
                end
            end
            gpx_pkg::CMD_READ:
            begin
                pending_next = gpx_pkg::CODE_NOP;
                if (pending_reg == gpx_pkg::CODE_GET_STATUS)
                begin
                    status_read = 1'b1;
                    irq_next    = 1'b0;
                end
            end
            default:
            begin
                // Unused command leaves the state alone.
            end
        endcase
    end

    // State registers advance only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < gpx_pkg::NUM_PORTS; p++)
            begin
                latched_reg[p] <= '0;
            end
            pending_reg <= gpx_pkg::CODE_NOP;
            irq_reg     <= 1'b0;
            asleep_reg  <= 1'b0;
        end
        else if (fire)
        begin
            latched_reg <= latched_next;
            pending_reg <= pending_next;
            irq_reg     <= irq_next;
            asleep_reg  <= asleep_next;
        end
    end

    // Reads never touch the latched levels, so the current values feed packing.
    assign latched           = latched_reg;
    assign flags.status_read = status_read;
    assign flags.irq         = irq_next;
    assign flags.asleep      = asleep_next;

endmodule
